FILE: design/awu_pkg.sv
package awu_pkg;

  // Configuration register indexes.
  localparam logic CfgLearnRate   = 1'b0;
  localparam logic CfgRegStrength = 1'b1;

  // Fixed-point constants.
  localparam logic signed [32:0] QHalf  = 33'sd8388608;
  localparam logic signed [40:0] S32Max = 41'sd2147483647;
  localparam logic signed [40:0] S32Min = -41'sd2147483648;

  // Widths of the square root and divider datapaths.
  localparam int RootW  = 32;
  localparam int RemW   = 35;
  localparam int QuotW  = 34;
  localparam int DivW   = 34;

  // Item fields carried alongside the square root.
  typedef struct packed {
    logic signed [31:0] w;
    logic               neg;
    logic               rhalf;
    logic               sat;
    logic [61:0]        num;
  } awu_side_t;

  // Item fields carried alongside the divider.
  typedef struct packed {
    logic signed [31:0] w;
    logic               neg;
    logic               sat;
    logic               zero;
    logic               ovf;
    logic [30:0]        acc;
  } awu_post_t;

endpackage

FILE: design/awu_prep.sv
module awu_prep
  import awu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic signed [31:0] w_in,
  input  logic signed [31:0] g_in,
  input  logic [30:0]        a_in,
  input  logic               thalf,
  input  logic               rhalf,
  input  logic [30:0]        lr,
  input  logic [30:0]        la,
  output logic               out_vld,
  output logic [63:0]        rad,
  output awu_side_t          side
);

  logic               v1, v2, v3;
  logic signed [31:0] w1, w2, w3;
  logic signed [31:0] g1;
  logic [30:0]        a1, a2;
  logic               rh1, rh2, rh3;
  logic               dneg1;
  logic [62:0]        pm1;
  logic               neg2, neg3;
  logic [31:0]        gm2;
  logic               sat2, sat3;
  logic [63:0]        sqg3;
  logic [61:0]        sqa3;
  logic [61:0]        num3;

  logic signed [32:0] diff;
  logic [31:0]        dmag;
  logic [62:0]        pr;
  logic signed [40:0] regv;
  logic signed [40:0] gsum;
  logic signed [31:0] gr;
  logic               gsat;

  // Stage 1: distance from the target and its product with the strength.
  always_comb begin
    diff = $signed({w_in[31], w_in}) - (thalf ? QHalf : 33'sd0);
    dmag = diff[32] ? 32'(-diff) : diff[31:0];
  end

  // Stage 2: round the regularization term and clamp the new gradient.
  always_comb begin
    pr   = pm1 + 63'h800000;
    regv = dneg1 ? -$signed({2'b00, pr[62:24]}) : $signed({2'b00, pr[62:24]});
    gsum = $signed({{9{g1[31]}}, g1}) + regv;
    gsat = 1'b0;
    if (gsum > S32Max) begin
      gr   = 32'sh7fffffff;
      gsat = 1'b1;
    end else if (gsum < S32Min) begin
      gr   = 32'sh80000000;
      gsat = 1'b1;
    end else begin
      gr = gsum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1      <= in_vld;
      v2      <= v1;
      v3      <= v2;
      out_vld <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1    <= w_in;
      g1    <= g_in;
      a1    <= a_in;
      rh1   <= rhalf;
      dneg1 <= diff[32];
      pm1   <= la * dmag;

      w2   <= w1;
      a2   <= a1;
      rh2  <= rh1;
      neg2 <= gr[31];
      gm2  <= gr[31] ? 32'(-gr) : gr;
      sat2 <= gsat;

      // Stage 3: squares and the step numerator, one product each.
      w3   <= w2;
      rh3  <= rh2;
      neg3 <= neg2;
      sat3 <= sat2;
      sqg3 <= gm2 * gm2;
      sqa3 <= a2 * a2;
      num3 <= 62'(lr * gm2);

      // Stage 4: radicand sum.
      rad        <= sqg3 + {2'b00, sqa3};
      side.w     <= w3;
      side.neg   <= neg3;
      side.rhalf <= rh3;
      side.sat   <= sat3;
      side.num   <= num3;
    end
  end

endmodule

FILE: design/awu_sqrt.sv
module awu_sqrt
  import awu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [63:0]       rad_in,
  input  awu_side_t         side_in,
  output logic              out_vld,
  output logic [RootW-1:0]  root_out,
  output logic [RemW-1:0]   rem_out,
  output awu_side_t         side_out
);

  logic             vld  [0:RootW];
  logic [63:0]      rad  [0:RootW];
  logic [RemW-1:0]  rem  [0:RootW];
  logic [RootW-1:0] root [0:RootW];
  awu_side_t        side [0:RootW];

  assign vld[0]  = in_vld;
  assign rad[0]  = rad_in;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = side_in;

  // One root bit per stage, restoring form.
  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RemW-1:0] rem2;
    logic [RemW-1:0] trial;

    always_comb begin
      rem2  = {rem[k][RemW-3:0], rad[k][63:62]};
      trial = {1'b0, root[k], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k+1]  <= {rad[k][61:0], 2'b00};
        side[k+1] <= side[k];
        if (rem2 >= trial) begin
          rem[k+1]  <= rem2 - trial;
          root[k+1] <= {root[k][RootW-2:0], 1'b1};
        end else begin
          rem[k+1]  <= rem2;
          root[k+1] <= {root[k][RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld[RootW];
  assign root_out = root[RootW];
  assign rem_out  = rem[RootW];
  assign side_out = side[RootW];

endmodule

FILE: design/awu_div.sv
module awu_div
  import awu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [RootW-1:0]  root_in,
  input  logic [RemW-1:0]   rem_in,
  input  awu_side_t         side_in,
  output logic              out_vld,
  output logic [QuotW-1:0]  quot_out,
  output awu_post_t         post_out
);

  logic              vld  [0:QuotW];
  logic [QuotW-1:0]  nlo  [0:QuotW];
  logic [DivW-1:0]   dv   [0:QuotW];
  logic [DivW-1:0]   rem  [0:QuotW];
  logic [QuotW-1:0]  quot [0:QuotW];
  awu_post_t         post [0:QuotW];

  logic [RootW-1:0] d;
  logic [32:0]      den;
  logic [DivW-1:0]  d2;
  logic [63:0]      n2;
  awu_post_t        pnext;

  // Round the root to nearest and form the rounded-quotient operands.
  always_comb begin
    d   = root_in + RootW'(rem_in > {3'b000, root_in});
    den = side_in.rhalf ? {d, 1'b0} : {1'b0, d};
    d2  = {den, 1'b0};
    n2  = {1'b0, side_in.num, 1'b0} + {31'd0, den};
    pnext.w    = side_in.w;
    pnext.neg  = side_in.neg;
    pnext.zero = (d == '0);
    pnext.ovf  = (d != '0) && ({4'b0000, n2[63:34]} >= d2);
    pnext.sat  = side_in.sat | d[31];
    pnext.acc  = d[31] ? 31'h7fffffff : d[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nlo[0]  <= n2[33:0];
      dv[0]   <= d2;
      rem[0]  <= {4'b0000, n2[63:34]};
      quot[0] <= '0;
      post[0] <= pnext;
    end
  end

  // One quotient bit per stage, restoring form.
  for (genvar j = 0; j < QuotW; j++) begin : g_stage
    logic [DivW:0] rem2;

    assign rem2 = {rem[j], nlo[j][QuotW-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nlo[j+1]  <= {nlo[j][QuotW-2:0], 1'b0};
        dv[j+1]   <= dv[j];
        post[j+1] <= post[j];
        if (rem2 >= {1'b0, dv[j]}) begin
          rem[j+1]  <= DivW'(rem2 - {1'b0, dv[j]});
          quot[j+1] <= {quot[j][QuotW-2:0], 1'b1};
        end else begin
          rem[j+1]  <= rem2[DivW-1:0];
          quot[j+1] <= {quot[j][QuotW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld[QuotW];
  assign quot_out = quot[QuotW];
  assign post_out = post[QuotW];

endmodule

FILE: design/adagrad_weight_update_top.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    weight_in grad_in accum_in target_half rate_half
// out       output     out_valid / out_ready  weight_out accum_out saturated
// cfg       input      cfg_valid / cfg_ready  cfg_index cfg_data
//
// One item enters per cycle while no result waits at the output; each result passes through the prep stages,
// the 32-stage square root, the 34-stage divider (one bit per stage) and the output register.
// Synchronous reset empties the pipeline and clears both registers to zero.
// When a result waits at the output, the whole pipeline holds and in_ready is low.
module adagrad_weight_update_top
  import awu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] weight_in,
  input  logic signed [31:0] grad_in,
  input  logic [30:0]        accum_in,
  input  logic               target_half,
  input  logic               rate_half,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] weight_out,
  output logic [30:0]        accum_out,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [30:0]       learn_rate;
  logic [30:0]       reg_strength;
  logic              en;
  logic              p_vld, s_vld, d_vld;
  logic [63:0]       rad;
  awu_side_t         p_side, s_side;
  logic [RootW-1:0]  root;
  logic [RemW-1:0]   rem;
  logic [QuotW-1:0]  quot;
  awu_post_t         post;
  logic signed [35:0] wn;
  logic [QuotW-1:0]  qv;

  // The pipeline advances whenever the output register can take a result.
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate   <= '0;
      reg_strength <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgLearnRate:   learn_rate   <= cfg_data[30:0];
        CfgRegStrength: reg_strength <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  awu_prep u_prep (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_valid && in_ready),
    .w_in    (weight_in),
    .g_in    (grad_in),
    .a_in    (accum_in),
    .thalf   (target_half),
    .rhalf   (rate_half),
    .lr      (learn_rate),
    .la      (reg_strength),
    .out_vld (p_vld),
    .rad     (rad),
    .side    (p_side)
  );

  awu_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (p_vld),
    .rad_in   (rad),
    .side_in  (p_side),
    .out_vld  (s_vld),
    .root_out (root),
    .rem_out  (rem),
    .side_out (s_side)
  );

  awu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s_vld),
    .root_in  (root),
    .rem_in   (rem),
    .side_in  (s_side),
    .out_vld  (d_vld),
    .quot_out (quot),
    .post_out (post)
  );

  // Apply the signed step to the weight.
  always_comb begin
    qv = post.zero ? '0 : quot;
    if (post.neg) begin
      wn = $signed({{4{post.w[31]}}, post.w}) + $signed({2'b00, qv});
    end else begin
      wn = $signed({{4{post.w[31]}}, post.w}) - $signed({2'b00, qv});
    end
  end

  // Output register with clamping.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      accum_out <= post.acc;
      if (post.ovf) begin
        weight_out <= post.neg ? 32'sh7fffffff : 32'sh80000000;
        saturated  <= 1'b1;
      end else if (wn > 36'sh07fffffff) begin
        weight_out <= 32'sh7fffffff;
        saturated  <= 1'b1;
      end else if (wn < -36'sh080000000) begin
        weight_out <= 32'sh80000000;
        saturated  <= 1'b1;
      end else begin
        weight_out <= wn[31:0];
        saturated  <= post.sat;
      end
    end
  end

endmodule

FILE: design/awu_checker.sv
module awu_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] weight_out,
  input logic [30:0]        accum_out,
  input logic               saturated,
  input logic               cfg_ready
);

  // A waiting result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(weight_out) && $stable(accum_out)
      && $stable(saturated))
    else $error("stalled result changed");

  // Input is taken exactly when the output side can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  // Configuration writes are never refused.
  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port stalled");

endmodule

bind adagrad_weight_update_top awu_checker u_awu_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .weight_out (weight_out),
  .accum_out  (accum_out),
  .saturated  (saturated),
  .cfg_ready  (cfg_ready)
);
